>>> rtl/core/brd_pkg.sv
package brd_pkg;

  // Bit buffer depth and widest field that one read returns.
  localparam int BUFFER_BITS    = 128;
  localparam int MAX_FIELD_BITS = 64;
  localparam int BYTE_BITS      = 8;

  localparam int FILL_W  = $clog2(BUFFER_BITS + 1);
  localparam int CMD_W   = 2;
  localparam int COUNT_W = 7;
  localparam int VALUE_W = 64;
  localparam int STAT_W  = 2;
  localparam int TOTAL_W = 48;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_SHORT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [7:0]         byte_in;
    logic [COUNT_W-1:0] bit_count;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] field_value;
    logic [STAT_W-1:0]  status;
    logic               byte_aligned;
    logic [TOTAL_W-1:0] bits_read_total;
  } res_t;

  // Mask of the n low bits; n of the full width or more gives all ones.
  function automatic logic [VALUE_W-1:0] low_mask(input logic [COUNT_W-1:0] n);
    logic [VALUE_W-1:0] m;
    if (n >= COUNT_W'(VALUE_W)) begin
      m = '1;
    end else begin
      m = (VALUE_W'(1) << n) - VALUE_W'(1);
    end
    return m;
  endfunction

endpackage

>>> rtl/core/brd_in_if.sv
interface brd_in_if;
  import brd_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [7:0]         byte_in;
  logic [COUNT_W-1:0] bit_count;

  modport source (output valid, command, byte_in, bit_count, input ready);
  modport sink   (input valid, command, byte_in, bit_count, output ready);
endinterface

>>> rtl/core/brd_out_if.sv
interface brd_out_if;
  import brd_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] field_value;
  logic [STAT_W-1:0]  status;
  logic               byte_aligned;
  logic [TOTAL_W-1:0] bits_read_total;

  modport source (output valid, field_value, status, byte_aligned, bits_read_total,
                  input ready);
  modport sink   (input valid, field_value, status, byte_aligned, bits_read_total,
                  output ready);
endinterface

>>> rtl/core/brd_exec.sv
module brd_exec
  import brd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  req_t req,
  output res_t res
);

  logic [BUFFER_BITS-1:0] store_r, store_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic [TOTAL_W-1:0]     total_r, total_nxt;

  logic [COUNT_W-1:0]     n_sat;
  logic [COUNT_W-1:0]     take;
  logic [FILL_W-1:0]      pos;
  logic [BUFFER_BITS-1:0] shifted;
  logic [STAT_W-1:0]      status;

  always_comb begin
    n_sat     = (req.bit_count > COUNT_W'(MAX_FIELD_BITS)) ? COUNT_W'(MAX_FIELD_BITS)
                                                           : req.bit_count;
    store_nxt = store_r;
    fill_nxt  = fill_r;
    status    = ST_OK;
    take      = '0;
    case (req.command)
      CMD_PUSH: begin
        if (fill_r > FILL_W'(BUFFER_BITS - BYTE_BITS)) begin
          status = ST_FULL;
        end else begin
          store_nxt = {store_r[BUFFER_BITS-BYTE_BITS-1:0], req.byte_in};
          fill_nxt  = fill_r + FILL_W'(BYTE_BITS);
        end
      end
      CMD_READ: begin
        if (FILL_W'(n_sat) > fill_r) begin
          status = ST_SHORT;
        end else begin
          take = n_sat;
        end
      end
      CMD_FLUSH: begin
        // Drop the unread tail of the current byte.
        take = COUNT_W'(fill_r[2:0]);
      end
      default: begin
      end
    endcase

    // The oldest unread bits sit just below fill_r; take them from the top.
    pos     = fill_r - FILL_W'(take);
    shifted = store_r >> pos;
    if (take != '0) begin
      fill_nxt = fill_r - FILL_W'(take);
    end
    total_nxt = total_r + TOTAL_W'(take);

    res.field_value     = shifted[VALUE_W-1:0] & low_mask(take);
    res.status          = status;
    res.byte_aligned    = (fill_nxt[2:0] == 3'd0);
    res.bits_read_total = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      fill_r  <= '0;
      total_r <= '0;
    end else if (fire) begin
      store_r <= store_nxt;
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(BUFFER_BITS))
    else $error("fill level above buffer size");

  a_reject_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (status != ST_OK) |=> (fill_r == $past(fill_r)) && $stable(total_r))
    else $error("rejected request changed the buffer");

  a_flush_aligns: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (req.command == CMD_FLUSH) |=> (fill_r[2:0] == 3'd0))
    else $error("flush left the buffer unaligned");

  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (req.command == CMD_PUSH) |=> $stable(total_r))
    else $error("push changed the consumed count");

endmodule

>>> rtl/core/msb_first_bit_reader.sv
// MSB-first bitstream reader.
// Requests arrive on in_ch: command 0 pushes byte_in into a 128-bit buffer,
// command 1 reads bit_count bits (saturated to 64) right-aligned, command 2
// drops the rest of the current byte and returns it right-aligned. Every
// request yields exactly one result on out_ch carrying the field value, a
// status (ok, not enough bits, buffer full), a byte-aligned flag and the
// 48-bit running count of bits consumed. Rejected requests change nothing.
// A request is taken into an input register; once the output register is free
// the barrel shift and bookkeeping finish and the result lands in the output
// register. One request per cycle is sustained while the receiver takes
// results; the buffer state is updated as each request advances, and that
// update is what sets it.
// When the receiver stalls, the result holds in the output register and one
// more request waits in the input register before in_ch.ready drops.
// Synchronous active-low reset empties the buffer, clears the count and
// drops both valid flags.
module msb_first_bit_reader
  import brd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  brd_in_if.sink    in_ch,
  brd_out_if.source out_ch
);

  // Input register stage.
  logic s1_valid_r;
  req_t s1_req_r;

  // Result register stage.
  logic out_valid_r;
  res_t out_res_r;

  logic advance;
  logic in_fire;
  res_t exec_res;

  // The request in the input register moves on whenever the output register
  // is empty or being emptied this cycle.
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_r.command   <= in_ch.command;
      s1_req_r.byte_in   <= in_ch.byte_in;
      s1_req_r.bit_count <= in_ch.bit_count;
    end
  end

  brd_exec u_exec (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .req   (s1_req_r),
    .res   (exec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= exec_res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.field_value     = out_res_r.field_value;
  assign out_ch.status          = out_res_r.status;
  assign out_ch.byte_aligned    = out_res_r.byte_aligned;
  assign out_ch.bits_read_total = out_res_r.bits_read_total;

  // A stalled result must not be overwritten by the next request.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !advance)
    else $error("result overwritten while stalled");

  // A request waiting in the input register is not lost: with the output
  // register empty it is in the result register on the following edge.
  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_valid_r |=> out_valid_r)
    else $error("request lost between stages");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ch.ready)
    else $error("input stalled while stage is empty");

endmodule
